// ----- src/sbgpd_pkg.sv -----
// Shared constants and types for the six-button gamepad poll decoder.
// No dependencies; used by sbgpd_pad_dec and six_button_gamepad_poll_decoder.
`default_nettype none

package sbgpd_pkg;

  // Poll cycle geometry.
  localparam int unsigned PHASE_COUNT = 8;
  localparam int unsigned PHASE_W     = 3;
  localparam int unsigned PAD_PINS    = 8;
  localparam int unsigned SNAP_W      = 2 * PAD_PINS;
  localparam int unsigned BTN_W       = 12;

  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(PHASE_COUNT - 1);

  // Phase codes that carry meaning.
  localparam logic [PHASE_W-1:0] PH_FRAME_START = PHASE_W'(0);
  localparam logic [PHASE_W-1:0] PH_DETECT      = PHASE_W'(2);
  localparam logic [PHASE_W-1:0] PH_DPAD        = PHASE_W'(3);
  localparam logic [PHASE_W-1:0] PH_SIX_CHECK   = PHASE_W'(4);
  localparam logic [PHASE_W-1:0] PH_EXTRA       = PHASE_W'(5);

  // Bit positions within a button word.
  localparam int unsigned BTN_UP    = 0;
  localparam int unsigned BTN_DOWN  = 1;
  localparam int unsigned BTN_LEFT  = 2;
  localparam int unsigned BTN_RIGHT = 3;
  localparam int unsigned BTN_B     = 4;
  localparam int unsigned BTN_C     = 5;
  localparam int unsigned BTN_A     = 6;
  localparam int unsigned BTN_START = 7;
  localparam int unsigned BTN_Z     = 8;
  localparam int unsigned BTN_Y     = 9;
  localparam int unsigned BTN_X     = 10;
  localparam int unsigned BTN_MODE  = 11;

  // Everything the decoder keeps per pad.
  typedef struct packed {
    logic [BTN_W-1:0] word;
    logic             on;
    logic             six;
  } pad_state_t;

endpackage

`default_nettype wire

// ----- src/six_button_gamepad_poll_decoder.sv -----
// Top level of the two-pad six-button gamepad poll decoder.
// Depends on sbgpd_pkg and instantiates sbgpd_pad_dec once per pad.
//
//   Channel | Direction | Handshake               | Word
//   --------+-----------+-------------------------+---------------------------------
//   in      | sink      | in_valid_i / in_stall_o  | pin_snapshot_i
//   out     | source    | out_valid_o / out_stall_i| select, done, buttons, flags
//
// Each word passes an input register and then a result register, and its
// result is presented once the decode stage has fired; one word is taken per
// cycle when the output side does not stall. The throughput is set by the
// single decode stage, which updates the poll phase and pad state in one step.
// Reset clears the phase, both pad states and both valid flags. A stalled
// output holds its word; the input register takes one more word and then
// stalls the input until the waiting result is taken.
`default_nettype none

module six_button_gamepad_poll_decoder (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [sbgpd_pkg::SNAP_W-1:0] pin_snapshot_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              select_level_o,
  output logic                              frame_done_o,
  output logic [sbgpd_pkg::BTN_W-1:0]       left_buttons_o,
  output logic [sbgpd_pkg::BTN_W-1:0]       right_buttons_o,
  output logic                              left_present_o,
  output logic                              right_present_o,
  output logic                              left_six_mode_o,
  output logic                              right_six_mode_o
);

  logic                             in_valid_q;
  logic [sbgpd_pkg::SNAP_W-1:0]     snap_q;
  logic                             out_valid_q;
  logic                             done_q;
  logic [sbgpd_pkg::PHASE_W-1:0]    phase_q;
  logic [sbgpd_pkg::PHASE_W-1:0]    phase_d;
  sbgpd_pkg::pad_state_t            left_q;
  sbgpd_pkg::pad_state_t            left_d;
  sbgpd_pkg::pad_state_t            right_q;
  sbgpd_pkg::pad_state_t            right_d;
  logic                             last_phase;
  logic                             advance;
  logic                             in_accept;

  // The decode stage fires when a word waits and the result register is free.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Phase bookkeeping: anything at or above the last phase ends the frame.
  assign last_phase = (phase_q >= sbgpd_pkg::LAST_PHASE);
  assign phase_d    = last_phase ? '0 : phase_q + sbgpd_pkg::PHASE_W'(1);

  // One decoder per pad.
  sbgpd_pad_dec u_left_dec (
    .phase_i (phase_q),
    .last_i  (last_phase),
    .pins_i  (snap_q[sbgpd_pkg::PAD_PINS-1:0]),
    .state_i (left_q),
    .state_o (left_d)
  );

  sbgpd_pad_dec u_right_dec (
    .phase_i (phase_q),
    .last_i  (last_phase),
    .pins_i  (snap_q[sbgpd_pkg::SNAP_W-1:sbgpd_pkg::PAD_PINS]),
    .state_i (right_q),
    .state_o (right_d)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      snap_q <= pin_snapshot_i;
    end
  end

  // Poll state and result register; the pad state doubles as the result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      done_q      <= 1'b0;
      phase_q     <= '0;
      left_q      <= '0;
      right_q     <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        done_q      <= last_phase;
        phase_q     <= phase_d;
        left_q      <= left_d;
        right_q     <= right_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign select_level_o   = phase_q[0];
  assign frame_done_o     = done_q;
  assign left_buttons_o   = left_q.word;
  assign right_buttons_o  = right_q.word;
  assign left_present_o   = left_q.on;
  assign right_present_o  = right_q.on;
  assign left_six_mode_o  = left_q.six;
  assign right_six_mode_o = right_q.six;

  // The phase counter never runs past the last phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= sbgpd_pkg::LAST_PHASE)
    else $error("poll phase beyond last phase");

  // A finished frame always restarts the select line low.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> !select_level_o)
    else $error("frame done without phase wrap");

  // At frame end a disconnected pad cannot report six-button mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q && (!left_q.on || !right_q.on) |->
      (left_q.on || !left_q.six) && (right_q.on || !right_q.six))
    else $error("six-button flag kept on a disconnected pad");

  // An accepted word is held in the input stage on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_valid_q)
    else $error("accepted word lost");

  // The pad state only changes when the decode stage fires.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(phase_q) && $stable(left_q) && $stable(right_q))
    else $error("pad state changed without a decode");

endmodule

`default_nettype wire

// ----- src/sbgpd_pad_dec.sv -----
// Per-pad decode of one active-low pin byte at one poll phase.
// Depends on sbgpd_pkg for phase codes, button positions and pad_state_t.
`default_nettype none

module sbgpd_pad_dec (
  input  wire logic [sbgpd_pkg::PHASE_W-1:0]  phase_i,
  input  wire logic                           last_i,
  input  wire logic [sbgpd_pkg::PAD_PINS-1:0] pins_i,
  input  wire sbgpd_pkg::pad_state_t          state_i,
  output sbgpd_pkg::pad_state_t               state_o
);

  logic [sbgpd_pkg::PAD_PINS-1:0] pressed;
  sbgpd_pkg::pad_state_t          cur;
  sbgpd_pkg::pad_state_t          nxt;

  // Pins are active low; one means the line is asserted.
  assign pressed = ~pins_i;

  always_comb begin
    // A new frame clears the words and the connected flag, but keeps six-button mode.
    cur = state_i;
    if (phase_i == sbgpd_pkg::PH_FRAME_START) begin
      cur.word = '0;
      cur.on   = 1'b0;
    end

    nxt = cur;
    case (phase_i)
      sbgpd_pkg::PH_DETECT: begin
        if (pressed[2] && pressed[3]) begin
          nxt.on = 1'b1;
        end
        if (nxt.on) begin
          nxt.word[sbgpd_pkg::BTN_A]     = cur.word[sbgpd_pkg::BTN_A] | pressed[4];
          nxt.word[sbgpd_pkg::BTN_START] = cur.word[sbgpd_pkg::BTN_START] | pressed[5];
        end
      end
      sbgpd_pkg::PH_DPAD: begin
        nxt.word[sbgpd_pkg::BTN_UP]    = cur.word[sbgpd_pkg::BTN_UP] | pressed[0];
        nxt.word[sbgpd_pkg::BTN_DOWN]  = cur.word[sbgpd_pkg::BTN_DOWN] | pressed[1];
        nxt.word[sbgpd_pkg::BTN_LEFT]  = cur.word[sbgpd_pkg::BTN_LEFT] | pressed[2];
        nxt.word[sbgpd_pkg::BTN_RIGHT] = cur.word[sbgpd_pkg::BTN_RIGHT] | pressed[3];
        nxt.word[sbgpd_pkg::BTN_B]     = cur.word[sbgpd_pkg::BTN_B] | pressed[4];
        nxt.word[sbgpd_pkg::BTN_C]     = cur.word[sbgpd_pkg::BTN_C] | pressed[5];
      end
      sbgpd_pkg::PH_SIX_CHECK: begin
        nxt.six = pressed[0] & pressed[1];
      end
      sbgpd_pkg::PH_EXTRA: begin
        if (cur.six) begin
          nxt.word[sbgpd_pkg::BTN_Z]    = cur.word[sbgpd_pkg::BTN_Z] | pressed[0];
          nxt.word[sbgpd_pkg::BTN_Y]    = cur.word[sbgpd_pkg::BTN_Y] | pressed[1];
          nxt.word[sbgpd_pkg::BTN_X]    = cur.word[sbgpd_pkg::BTN_X] | pressed[2];
          nxt.word[sbgpd_pkg::BTN_MODE] = cur.word[sbgpd_pkg::BTN_MODE] | pressed[3];
        end
      end
      default: begin
        nxt = cur;
      end
    endcase

    // At the end of a frame a pad that is not connected drops six-button mode.
    if (last_i && !nxt.on) begin
      nxt.six = 1'b0;
    end
  end

  assign state_o = nxt;

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Testbench for six_button_gamepad_poll_decoder: directed poll frames, then random snapshots
// weighted toward connected and six-button pads, each result word checked field by field.
// Depends on sbgpd_pkg and the decoder RTL; stands alone otherwise.

module tb;

  // One result word as the decoder presents it.
  typedef struct packed {
    logic                        select_level;
    logic                        frame_done;
    logic [sbgpd_pkg::BTN_W-1:0] left_buttons;
    logic [sbgpd_pkg::BTN_W-1:0] right_buttons;
    logic                        left_present;
    logic                        right_present;
    logic                        left_six_mode;
    logic                        right_six_mode;
  } poll_word_t;

  // One row of the directed table; want is used only when typed is set.
  typedef struct packed {
    logic [sbgpd_pkg::SNAP_W-1:0] snap;
    logic                         typed;
    poll_word_t                   want;
  } stim_row_t;

  localparam int RANDOM_WORDS  = 1400;
  localparam int DIRECTED_ROWS = 24;
  localparam int DRAIN_CYCLES  = 10;
  localparam int PRESSURE_AT   = 400;
  localparam int PRESSURE_HOLD = 80;

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         in_valid_i     = 1'b0;
  logic [sbgpd_pkg::SNAP_W-1:0] pin_snapshot_i = '0;
  logic                         out_stall_i    = 1'b0;
  logic                         in_stall_o;
  logic                         out_valid_o;
  logic                         select_level_o;
  logic                         frame_done_o;
  logic [sbgpd_pkg::BTN_W-1:0]  left_buttons_o;
  logic [sbgpd_pkg::BTN_W-1:0]  right_buttons_o;
  logic                         left_present_o;
  logic                         right_present_o;
  logic                         left_six_mode_o;
  logic                         right_six_mode_o;

  // Behavioral copy of the decoder state.
  logic [sbgpd_pkg::PHASE_W-1:0] poll_phase = '0;
  sbgpd_pkg::pad_state_t         left_pad   = '0;
  sbgpd_pkg::pad_state_t         right_pad  = '0;

  poll_word_t  pending_q [$];
  stim_row_t   directed_q [$];
  int unsigned words_in       = 0;
  int unsigned mismatch_count = 0;

  six_button_gamepad_poll_decoder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pin_snapshot_i  (pin_snapshot_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .select_level_o  (select_level_o),
    .frame_done_o    (frame_done_o),
    .left_buttons_o  (left_buttons_o),
    .right_buttons_o (right_buttons_o),
    .left_present_o  (left_present_o),
    .right_present_o (right_present_o),
    .left_six_mode_o (left_six_mode_o),
    .right_six_mode_o(right_six_mode_o)
  );

  always #4 clk_i = ~clk_i;

  // Decode one pad's pins (one means asserted) for the given phase.
  function automatic sbgpd_pkg::pad_state_t decode_pad_pins(
      input logic [sbgpd_pkg::PHASE_W-1:0]  phase,
      input sbgpd_pkg::pad_state_t          st,
      input logic [sbgpd_pkg::PAD_PINS-1:0] pressed);
    sbgpd_pkg::pad_state_t nxt;
    nxt = st;
    case (phase)
      sbgpd_pkg::PH_DETECT: begin
        if (pressed[2] && pressed[3]) nxt.on = 1'b1;
        if (nxt.on) begin
          if (pressed[4]) nxt.word[sbgpd_pkg::BTN_A] = 1'b1;
          if (pressed[5]) nxt.word[sbgpd_pkg::BTN_START] = 1'b1;
        end
      end
      sbgpd_pkg::PH_DPAD: begin
        if (pressed[0]) nxt.word[sbgpd_pkg::BTN_UP] = 1'b1;
        if (pressed[1]) nxt.word[sbgpd_pkg::BTN_DOWN] = 1'b1;
        if (pressed[2]) nxt.word[sbgpd_pkg::BTN_LEFT] = 1'b1;
        if (pressed[3]) nxt.word[sbgpd_pkg::BTN_RIGHT] = 1'b1;
        if (pressed[4]) nxt.word[sbgpd_pkg::BTN_B] = 1'b1;
        if (pressed[5]) nxt.word[sbgpd_pkg::BTN_C] = 1'b1;
      end
      sbgpd_pkg::PH_SIX_CHECK: begin
        nxt.six = pressed[0] & pressed[1];
      end
      sbgpd_pkg::PH_EXTRA: begin
        if (nxt.six) begin
          if (pressed[0]) nxt.word[sbgpd_pkg::BTN_Z] = 1'b1;
          if (pressed[1]) nxt.word[sbgpd_pkg::BTN_Y] = 1'b1;
          if (pressed[2]) nxt.word[sbgpd_pkg::BTN_X] = 1'b1;
          if (pressed[3]) nxt.word[sbgpd_pkg::BTN_MODE] = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return nxt;
  endfunction

  // Advance the poll by one snapshot and return the word the decoder should emit.
  function automatic poll_word_t advance_poll(input logic [sbgpd_pkg::SNAP_W-1:0] snap);
    poll_word_t res;
    logic       frame_end;
    if (poll_phase == sbgpd_pkg::PH_FRAME_START) begin
      left_pad.word  = '0;
      left_pad.on    = 1'b0;
      right_pad.word = '0;
      right_pad.on   = 1'b0;
    end
    left_pad  = decode_pad_pins(poll_phase, left_pad, ~snap[sbgpd_pkg::PAD_PINS-1:0]);
    right_pad = decode_pad_pins(poll_phase, right_pad,
                                ~snap[sbgpd_pkg::SNAP_W-1:sbgpd_pkg::PAD_PINS]);
    frame_end = (poll_phase >= sbgpd_pkg::LAST_PHASE);
    if (frame_end) begin
      if (!left_pad.on) left_pad.six = 1'b0;
      if (!right_pad.on) right_pad.six = 1'b0;
      poll_phase = '0;
    end else begin
      poll_phase = poll_phase + 1'b1;
    end
    res.select_level   = poll_phase[0];
    res.frame_done     = frame_end;
    res.left_buttons   = left_pad.word;
    res.right_buttons  = right_pad.word;
    res.left_present   = left_pad.on;
    res.right_present  = right_pad.on;
    res.left_six_mode  = left_pad.six;
    res.right_six_mode = right_pad.six;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [sbgpd_pkg::BTN_W-1:0] want,
                             input logic [sbgpd_pkg::BTN_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Accepted snapshots feed the predictor; accepted results are checked in order.
  always @(posedge clk_i) begin
    poll_word_t predicted;
    poll_word_t want;
    stim_row_t  row;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predicted = advance_poll(pin_snapshot_i);
        words_in++;
        if (directed_q.size() != 0) begin
          row = directed_q.pop_front();
          if (row.typed) predicted = row.want;
        end
        pending_q.push_back(predicted);
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_q.size() == 0) begin
          $error("result word arrived with no expectation pending");
          mismatch_count++;
        end else begin
          want = pending_q.pop_front();
          check_field("select_level", sbgpd_pkg::BTN_W'(want.select_level),
                      sbgpd_pkg::BTN_W'(select_level_o));
          check_field("frame_done", sbgpd_pkg::BTN_W'(want.frame_done),
                      sbgpd_pkg::BTN_W'(frame_done_o));
          check_field("left_buttons", want.left_buttons, left_buttons_o);
          check_field("right_buttons", want.right_buttons, right_buttons_o);
          check_field("left_present", sbgpd_pkg::BTN_W'(want.left_present),
                      sbgpd_pkg::BTN_W'(left_present_o));
          check_field("right_present", sbgpd_pkg::BTN_W'(want.right_present),
                      sbgpd_pkg::BTN_W'(right_present_o));
          check_field("left_six_mode", sbgpd_pkg::BTN_W'(want.left_six_mode),
                      sbgpd_pkg::BTN_W'(left_six_mode_o));
          check_field("right_six_mode", sbgpd_pkg::BTN_W'(want.right_six_mode),
                      sbgpd_pkg::BTN_W'(right_six_mode_o));
        end
      end
    end
  end

  // Mostly back-to-back words, some short gaps, a few long ones, and gap-free stretches.
  function automatic int unsigned pick_gap(input int unsigned n);
    int unsigned r;
    r = $urandom_range(0, 99);
    if ((n / 200) % 3 == 1) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Pins of one pad, usually shaped so that the pad connects and enters six-button mode.
  function automatic logic [sbgpd_pkg::PAD_PINS-1:0] pad_pins(
      input logic [sbgpd_pkg::PHASE_W-1:0] phase);
    logic [sbgpd_pkg::PAD_PINS-1:0] pins;
    int unsigned                    r;
    pins = sbgpd_pkg::PAD_PINS'($urandom);
    r    = $urandom_range(0, 7);
    if (r < 5) begin
      if (phase == sbgpd_pkg::PH_DETECT) pins[3:2] = 2'b00;
      if (phase == sbgpd_pkg::PH_SIX_CHECK) pins[1:0] = 2'b00;
    end else if (r == 7) begin
      pins = '1;
    end
    return pins;
  endfunction

  // Offer one word, hold it until it is taken, and return at the next falling edge.
  task automatic send_snapshot(input logic [sbgpd_pkg::SNAP_W-1:0] snap,
                               input int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    pin_snapshot_i <= snap;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Sender: reset, the directed frames, then random frames, then drain and report.
  initial begin : sender
    stim_row_t                     rows [DIRECTED_ROWS];
    logic [sbgpd_pkg::PHASE_W-1:0] drv_phase;
    rows = '{
      // Frame of released pads: nothing connected, nothing pressed.
      {16'hFFFF, 1'b1, {1'b1, 1'b0, 12'h000, 12'h000, 4'b0000}},
      {16'hFFFF, 1'b1, {1'b0, 1'b0, 12'h000, 12'h000, 4'b0000}},
      {16'hFFFF, 1'b1, {1'b1, 1'b0, 12'h000, 12'h000, 4'b0000}},
      {16'hFFFF, 1'b1, {1'b0, 1'b0, 12'h000, 12'h000, 4'b0000}},
      {16'hFFFF, 1'b1, {1'b1, 1'b0, 12'h000, 12'h000, 4'b0000}},
      {16'hFFFF, 1'b1, {1'b0, 1'b0, 12'h000, 12'h000, 4'b0000}},
      {16'hFFFF, 1'b1, {1'b1, 1'b0, 12'h000, 12'h000, 4'b0000}},
      {16'hFFFF, 1'b1, {1'b0, 1'b1, 12'h000, 12'h000, 4'b0000}},
      // Frame with every pin asserted: both pads connected, six-button, all pressed.
      {16'h0000, 1'b1, {1'b1, 1'b0, 12'h000, 12'h000, 4'b0000}},
      {16'h0000, 1'b1, {1'b0, 1'b0, 12'h000, 12'h000, 4'b0000}},
      {16'h0000, 1'b1, {1'b1, 1'b0, 12'h0C0, 12'h0C0, 4'b1100}},
      {16'h0000, 1'b1, {1'b0, 1'b0, 12'h0FF, 12'h0FF, 4'b1100}},
      {16'h0000, 1'b1, {1'b1, 1'b0, 12'h0FF, 12'h0FF, 4'b1111}},
      {16'h0000, 1'b1, {1'b0, 1'b0, 12'hFFF, 12'hFFF, 4'b1111}},
      {16'h0000, 1'b1, {1'b1, 1'b0, 12'hFFF, 12'hFFF, 4'b1111}},
      {16'h0000, 1'b1, {1'b0, 1'b1, 12'hFFF, 12'hFFF, 4'b1111}},
      // Mixed frame: unused pins asserted, six flags carried over the frame start,
      // left connected without six-button mode, right in six-button mode while
      // not connected so that its extra keys land and its flag drops at frame end.
      {16'h3F3F, 1'b0, 30'h0},
      {16'h0000, 1'b0, 30'h0},
      {16'hCFE3, 1'b0, 30'h0},
      {16'hC5FA, 1'b0, 30'h0},
      {16'hFCFE, 1'b0, 30'h0},
      {16'h0000, 1'b0, 30'h0},
      {16'h5A5A, 1'b0, 30'h0},
      {16'hA5A5, 1'b0, 30'h0}
    };
    drv_phase = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      directed_q.push_back(rows[i]);
      send_snapshot(rows[i].snap, pick_gap(i));
    end

    // The directed rows cover whole frames, so the poll is back at phase zero here.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      send_snapshot({pad_pins(drv_phase), pad_pins(drv_phase)}, pick_gap(n));
      drv_phase = (drv_phase >= sbgpd_pkg::LAST_PHASE) ? sbgpd_pkg::PH_FRAME_START
                                                       : drv_phase + 1'b1;
    end
    in_valid_i <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver: random stall runs, quiet stretches, and one long hold that backs up the input.
  initial begin : receiver
    int unsigned run_left;
    int unsigned hold_left;
    int unsigned cycle_no;
    logic        stall_now;
    bit          pressure_done;
    run_left      = 0;
    hold_left     = 0;
    cycle_no      = 0;
    stall_now     = 1'b0;
    pressure_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cycle_no++;
      if (hold_left > 0) begin
        hold_left--;
        stall_now = 1'b1;
      end else if (!pressure_done && words_in >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold_left     = PRESSURE_HOLD;
        stall_now     = 1'b1;
      end else if ((cycle_no / 1500) % 4 == 3) begin
        stall_now = 1'b0;
      end else begin
        if (run_left == 0) begin
          stall_now = ($urandom_range(0, 99) < 30);
          if (stall_now) begin
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                   : $urandom_range(1, 3);
          end else begin
            run_left = $urandom_range(1, 12);
          end
        end
        run_left--;
      end
      out_stall_i <= stall_now;
    end
  end

  // Hard limit well beyond the slowest legal run.
  initial begin : watchdog
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
